/* hw/rtl/collective_route_address_map_defines.svh */
// Assertion macros used by the checker of the collective route address map.
`ifndef COLLECTIVE_ROUTE_ADDRESS_MAP_DEFINES_SVH
`define COLLECTIVE_ROUTE_ADDRESS_MAP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CRAM_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define CRAM_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

/* hw/rtl/cram_pkg.sv */
// Package of the collective route address map: widths, codes and defaults.
package cram_pkg;

  localparam int CRAM_MAX_DIMS = 3;
  localparam int CRAM_MAX_PES  = 4096;

  localparam int PE_W   = 12;
  localparam int OFF_W  = 24;
  localparam int DIM_W  = 13;
  localparam int CHK_W  = 12;
  localparam int ST_W   = 3;
  localparam int ADDR_W = 5;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_CFG_BAD   = 3'd1,
    ST_PE_RANGE  = 3'd2,
    ST_NO_OUTPUT = 3'd3,
    ST_OFF_OVER  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    REG_NUM_DIMS  = 3'd0,
    REG_DIM0      = 3'd1,
    REG_DIM1      = 3'd2,
    REG_DIM2      = 3'd3,
    REG_LINE_DIM  = 3'd4,
    REG_MODE      = 3'd5,
    REG_ROOT      = 3'd6,
    REG_CHUNK     = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_BCAST      = 2'd0,
    MODE_SCATTER    = 2'd1,
    MODE_GATHER_ONE = 2'd2,
    MODE_GATHER_ALL = 2'd3
  } mode_t;

endpackage

/* hw/rtl/cram_div.sv */
// Pipelined restoring divider, SPS quotient bits per register stage.
module cram_div #(
  parameter int NW  = 12,
  parameter int DW  = 13,
  parameter int SPS = 4
) (
  input  logic                          clk,
  input  logic [(NW+SPS-1)/SPS-1:0]     en,
  input  logic [NW-1:0]                 num,
  input  logic [DW-1:0]                 den,
  output logic [NW-1:0]                 quo,
  output logic [DW-1:0]                 rem
);

  localparam int STG = (NW + SPS - 1) / SPS;

  logic [NW-1:0] q_r [STG];
  logic [DW-1:0] r_r [STG];
  logic [DW-1:0] d_r [STG];

  for (genvar s = 0; s < STG; s++) begin : g_stage
    logic [NW-1:0] q_in;
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [NW-1:0] q_nxt;
    logic [DW:0]   r_wide;

    if (s == 0) begin : g_first
      assign q_in = num;
      assign r_in = '0;
      assign d_in = den;
    end else begin : g_rest
      assign q_in = q_r[s-1];
      assign r_in = r_r[s-1];
      assign d_in = d_r[s-1];
    end

    // shift one numerator bit in per step, subtract when it fits
    always_comb begin
      q_nxt  = q_in;
      r_wide = {1'b0, r_in};
      for (int k = 0; k < SPS; k++) begin
        if (s * SPS + k < NW) begin
          r_wide = {r_wide[DW-1:0], q_nxt[NW-1]};
          q_nxt  = {q_nxt[NW-2:0], 1'b0};
          if (r_wide >= {1'b0, d_in}) begin
            r_wide   = r_wide - {1'b0, d_in};
            q_nxt[0] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        q_r[s] <= q_nxt;
        r_r[s] <= r_wide[DW-1:0];
        d_r[s] <= d_in;
      end
    end
  end

  assign quo = q_r[STG-1];
  assign rem = r_r[STG-1];

endmodule

/* hw/rtl/collective_route_address_map.sv */
// Top level of the collective route address map.
// Usage:
//   in_* stream: one request per transfer, tdata = {byte_offset, pe_index}.
//   out_* stream: one result per request, in request order:
//     tdata = {out_size, source_byte, source_pe, status}.
//   cfg_* APB port: eight registers at byte addresses 0x00..0x1C, pready
//   always high; write only while no request is in flight.
// Throughput: one request per cycle while out_* does not stall. The
//   depth is set by the two chained PE-index dividers (line coordinate)
//   running beside the byte-offset divider, four quotient bits per
//   stage, then a multiply stage and an add stage.
// Each stage has its own valid bit; a stage holds while its successor is
//   full and stalled, so a stalled receiver fills the pipe and then
//   in_tready drops. Nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipe and restores the
//   register defaults: one dimension of extent one, broadcast, root zero,
//   one-byte chunks.
module collective_route_address_map #(
  parameter int MAX_DIMS = cram_pkg::CRAM_MAX_DIMS,
  parameter int MAX_PES  = cram_pkg::CRAM_MAX_PES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [39:0]               in_tdata,   // pe_index[11:0], byte_offset[35:12]
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [63:0]               out_tdata,  // status[2:0], source_pe[14:3],
                                                // source_byte[38:15], out_size[62:39]
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [cram_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);

  import cram_pkg::*;

  localparam int LAST = 8;

  // configuration registers
  logic [1:0]       num_dims_r;
  logic [DIM_W-1:0] dim0_r, dim1_r, dim2_r;
  logic [1:0]       line_dim_r;
  logic [1:0]       mode_r;
  logic [PE_W-1:0]  root_r;
  logic [CHK_W-1:0] chunk_r;

  logic     wr_en;
  reg_idx_t wr_idx;

  assign cfg_pready = 1'b1;
  assign wr_en  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign wr_idx = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r <= 2'd1;
      dim0_r     <= DIM_W'(1);
      dim1_r     <= DIM_W'(1);
      dim2_r     <= DIM_W'(1);
      line_dim_r <= 2'd0;
      mode_r     <= MODE_BCAST;
      root_r     <= '0;
      chunk_r    <= CHK_W'(1);
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_NUM_DIMS: num_dims_r <= cfg_pwdata[1:0];
        REG_DIM0:     dim0_r     <= cfg_pwdata[DIM_W-1:0];
        REG_DIM1:     dim1_r     <= cfg_pwdata[DIM_W-1:0];
        REG_DIM2:     dim2_r     <= cfg_pwdata[DIM_W-1:0];
        REG_LINE_DIM: line_dim_r <= cfg_pwdata[1:0];
        REG_MODE:     mode_r     <= cfg_pwdata[1:0];
        REG_ROOT:     root_r     <= cfg_pwdata[PE_W-1:0];
        REG_CHUNK:    chunk_r    <= cfg_pwdata[CHK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_NUM_DIMS: cfg_prdata = 32'(num_dims_r);
      REG_DIM0:     cfg_prdata = 32'(dim0_r);
      REG_DIM1:     cfg_prdata = 32'(dim1_r);
      REG_DIM2:     cfg_prdata = 32'(dim2_r);
      REG_LINE_DIM: cfg_prdata = 32'(line_dim_r);
      REG_MODE:     cfg_prdata = 32'(mode_r);
      REG_ROOT:     cfg_prdata = 32'(root_r);
      REG_CHUNK:    cfg_prdata = 32'(chunk_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // derived configuration, registered; bad_r settles after nr_r, nr_r after p01_r
  logic [DIM_W-1:0]   d1u, d2u;
  logic [2*DIM_W-1:0] p01_r;
  logic [3*DIM_W-1:0] nr_r;
  logic [DIM_W-1:0]   stride_r;
  logic [DIM_W-1:0]   ext_r;
  logic [OFF_W-1:0]   size_r;
  logic               bad_r;
  logic [2*DIM_W-1:0] d01;
  logic [CHK_W+DIM_W-1:0] cxe;
  logic               gather;

  assign d1u    = (num_dims_r >= 2'd2) ? dim1_r : DIM_W'(1);
  assign d2u    = (num_dims_r >= 2'd3) ? dim2_r : DIM_W'(1);
  assign d01    = dim0_r * dim1_r;
  assign cxe    = chunk_r * ext_r;
  assign gather = (mode_r == MODE_GATHER_ONE) || (mode_r == MODE_GATHER_ALL);

  always_ff @(posedge clk) begin
    p01_r <= dim0_r * d1u;
    nr_r  <= p01_r * d2u;
    case (line_dim_r)
      2'd1:    stride_r <= dim0_r;
      2'd2:    stride_r <= d01[DIM_W-1:0];
      default: stride_r <= DIM_W'(1);
    endcase
    case (line_dim_r)
      2'd0:    ext_r <= dim0_r;
      2'd1:    ext_r <= dim1_r;
      2'd2:    ext_r <= dim2_r;
      default: ext_r <= DIM_W'(1);
    endcase
    size_r <= gather ? cxe[OFF_W-1:0] : OFF_W'(chunk_r);
    bad_r  <= (num_dims_r == 2'd0) || (32'(num_dims_r) > MAX_DIMS) ||
              (line_dim_r >= num_dims_r) || (chunk_r == '0) || (dim0_r == '0) ||
              ((num_dims_r >= 2'd2) && (dim1_r == '0)) ||
              ((num_dims_r >= 2'd3) && (dim2_r == '0)) ||
              ({1'b0, root_r} >= ext_r) || (nr_r > (3*DIM_W)'(MAX_PES));
  end

  // pipeline control
  logic [LAST:0] v_r;
  logic [LAST:0] rdy;

  always_comb begin
    rdy[LAST] = !v_r[LAST] || out_tready;
    for (int i = LAST - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = v_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_tvalid;
      for (int i = 1; i <= LAST; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // request fields delayed alongside the dividers
  logic [PE_W-1:0]  pe_r  [7];
  logic [OFF_W-1:0] off_r [7];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pe_r[0]  <= in_tdata[PE_W-1:0];
      off_r[0] <= in_tdata[PE_W+OFF_W-1:PE_W];
    end
    for (int i = 1; i < 7; i++) begin
      if (rdy[i]) begin
        pe_r[i]  <= pe_r[i-1];
        off_r[i] <= off_r[i-1];
      end
    end
  end

  // line coordinate = (pe / stride) % ext; chunk index = offset / chunk
  logic [PE_W-1:0]  qa, qb;
  logic [DIM_W-1:0] ra, rb;
  logic [OFF_W-1:0] qc;
  logic [CHK_W-1:0] rc;

  cram_div #(.NW(PE_W), .DW(DIM_W), .SPS(4)) u_div_a (
    .clk (clk), .en (rdy[3:1]), .num (pe_r[0]), .den (stride_r), .quo (qa), .rem (ra)
  );

  cram_div #(.NW(PE_W), .DW(DIM_W), .SPS(4)) u_div_b (
    .clk (clk), .en (rdy[6:4]), .num (qa), .den (ext_r), .quo (qb), .rem (rb)
  );

  cram_div #(.NW(OFF_W), .DW(CHK_W), .SPS(4)) u_div_c (
    .clk (clk), .en (rdy[6:1]), .num (off_r[0]), .den (chunk_r), .quo (qc), .rem (rc)
  );

  // stage 7: status and products
  logic [PE_W-1:0]    coord;
  logic [PE_W-1:0]    xsel;
  logic [2*PE_W-1:0]  mcs_full, mx_full;
  logic [2*CHK_W-1:0] mcc_full;
  status_t            st_nxt;

  logic [PE_W-1:0]  pe7_r, mcs7_r, mx7_r;
  logic [OFF_W-1:0] sbase7_r, sadd7_r, size7_r;
  status_t          st7_r;

  assign coord    = rb[PE_W-1:0];
  assign xsel     = gather ? qc[PE_W-1:0] : root_r;
  assign mcs_full = coord * stride_r[PE_W-1:0];
  assign mx_full  = xsel * stride_r[PE_W-1:0];
  assign mcc_full = coord * chunk_r;

  always_comb begin
    if (bad_r) begin
      st_nxt = ST_CFG_BAD;
    end else if ((3*DIM_W)'(pe_r[6]) >= nr_r) begin
      st_nxt = ST_PE_RANGE;
    end else if ((mode_r == MODE_GATHER_ONE) && (coord != root_r)) begin
      st_nxt = ST_NO_OUTPUT;
    end else if (off_r[6] >= size_r) begin
      st_nxt = ST_OFF_OVER;
    end else begin
      st_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      st7_r    <= st_nxt;
      pe7_r    <= pe_r[6];
      mcs7_r   <= mcs_full[PE_W-1:0];
      mx7_r    <= mx_full[PE_W-1:0];
      sbase7_r <= gather ? OFF_W'(rc) : off_r[6];
      sadd7_r  <= (mode_r == MODE_SCATTER) ? mcc_full[OFF_W-1:0] : '0;
      size7_r  <= size_r;
    end
  end

  // stage 8: output register
  status_t          st8_r;
  logic [PE_W-1:0]  src8_r;
  logic [OFF_W-1:0] sb8_r, size8_r;

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      st8_r   <= st7_r;
      src8_r  <= (st7_r == ST_OK) ? (pe7_r - mcs7_r + mx7_r) : '0;
      sb8_r   <= (st7_r == ST_OK) ? (sbase7_r + sadd7_r) : '0;
      size8_r <= ((st7_r == ST_OK) || (st7_r == ST_OFF_OVER)) ? size7_r : '0;
    end
  end

  assign out_tdata = {1'b0, size8_r, sb8_r, src8_r, st8_r};

endmodule

/* hw/rtl/cram_checker.sv */
// Port-level checker of the collective route address map, with its bind.
`include "collective_route_address_map_defines.svh"

module cram_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  import cram_pkg::*;

  logic [2:0] st;
  logic       stall;
  logic       err_any;
  logic       err_no_size;

  assign st          = out_tdata[2:0];
  assign stall       = out_tvalid && !out_tready;
  assign err_any     = out_tvalid && (st != ST_OK);
  assign err_no_size = out_tvalid &&
                       ((st == ST_CFG_BAD) || (st == ST_PE_RANGE) || (st == ST_NO_OUTPUT));

  `CRAM_ASSERT_NXT(a_out_hold, clk, rst_n, stall, out_tvalid)
  `CRAM_ASSERT_NXT(a_out_stable, clk, rst_n, stall, $stable(out_tdata))
  `CRAM_ASSERT_IMP(a_err_zero_src, clk, rst_n, err_any, out_tdata[38:3] == '0)
  `CRAM_ASSERT_IMP(a_err_zero_size, clk, rst_n, err_no_size, out_tdata[62:39] == '0)

endmodule

bind collective_route_address_map cram_checker u_cram_checker (.*);
